[rtl/lzrk_pkg.sv]
// ----------------------------------------------------------------------------
// lzrk_pkg
// shared widths, codes and types of the landau-zener rk4 step pipeline
// ----------------------------------------------------------------------------
package lzrk_pkg;

  localparam int WORD_W        = 32;
  localparam int AMP_WIDTH_DEF = 32;
  localparam int AMP_W_MIN     = 16;
  localparam int AMP_W_MAX     = 32;
  localparam int K_W           = 42;  // stage derivative width
  localparam int SUM_W         = 45;  // k1 + 2k2 + 2k3 + k4
  localparam int MUL_W         = 34;  // step weight width (h or h/6 in q0.35)
  localparam int SLOPE_W       = 48;
  localparam int CFG_W         = 48;
  localparam int CIDX_W        = 2;
  localparam int IN_W          = 224;
  localparam int OUT_W         = 160;

  typedef enum logic [CIDX_W-1:0] {
    REG_COUPLING    = 2'd0,
    REG_FIELD_START = 2'd1,
    REG_FIELD_SLOPE = 2'd2,
    REG_STEP_SIZE   = 2'd3
  } cfg_reg_t;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [3:0]              amp4_t;
  typedef logic signed [K_W-1:0]    kval_t;
  typedef kval_t [3:0]              k4_t;
  typedef logic signed [SUM_W-1:0]  sval_t;
  typedef sval_t [3:0]              s4_t;

  typedef struct packed {
    word_t              coupling;
    word_t              field_start;
    logic               neg;
    logic [SLOPE_W-1:0] slope_mag;
    logic [WORD_W-1:0]  h;
    logic [MUL_W-1:0]   h6;
  } cfg_t;

  typedef struct packed {
    amp4_t             a;
    word_t             cs;
    word_t             sn;
    logic [WORD_W-1:0] step;
    word_t             s;
    word_t             g0;
    word_t             g1;
    word_t             g2;
    k4_t               k1;
    k4_t               k2;
    k4_t               k3;
    k4_t               k4;
    amp4_t             st;
    s4_t               sum;
    amp4_t             res;
    logic              ovf;
  } ctx_t;

endpackage

[rtl/lzrk_cfg.sv]
// ----------------------------------------------------------------------------
// lzrk_cfg
// configuration registers and the values derived from them (|slope|, h/6)
// ----------------------------------------------------------------------------
module lzrk_cfg import lzrk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output cfg_t              cfg
);

  // ceil(2^36 / 3)
  localparam logic [34:0] RECIP3 = 35'h5_5555_5556;

  logic [WORD_W-1:0]  coupling_r;
  logic [WORD_W-1:0]  field_start_r;
  logic [SLOPE_W-1:0] slope_r;
  logic [WORD_W-1:0]  step_size_r;
  logic [MUL_W-1:0]   x4h;
  logic [51:0]        ph_nxt, pl_nxt, ph_r, pl_r;
  logic [69:0]        prod;
  logic [MUL_W-1:0]   h6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coupling_r    <= 32'd16777216;
      field_start_r <= 32'd8388608;
      slope_r       <= '0;
      step_size_r   <= 32'd4294967;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COUPLING:    coupling_r    <= cfg_data[WORD_W-1:0];
        REG_FIELD_START: field_start_r <= cfg_data[WORD_W-1:0];
        REG_FIELD_SLOPE: slope_r       <= cfg_data[SLOPE_W-1:0];
        REG_STEP_SIZE:   step_size_r   <= cfg_data[WORD_W-1:0];
        default:         slope_r       <= slope_r;
      endcase
    end
  end

  // h/6 in q0.35 = floor((4h + 1) / 3), reciprocal multiply in two halves
  assign x4h    = {step_size_r, 2'b00} + MUL_W'(1);
  assign ph_nxt = 52'(x4h[33:17]) * 52'(RECIP3);
  assign pl_nxt = 52'(x4h[16:0]) * 52'(RECIP3);
  assign prod   = 70'({ph_r, 17'd0}) + 70'(pl_r);

  always_ff @(posedge clk) begin
    ph_r <= ph_nxt;
    pl_r <= pl_nxt;
    h6_r <= prod[69:36];
  end

  assign cfg.coupling    = coupling_r;
  assign cfg.field_start = field_start_r;
  assign cfg.neg         = slope_r[SLOPE_W-1];
  assign cfg.slope_mag   = slope_r[SLOPE_W-1] ? (~slope_r + SLOPE_W'(1)) : slope_r;
  assign cfg.h           = step_size_r;
  assign cfg.h6          = h6_r;

endmodule

[rtl/lzrk_coef.sv]
// ----------------------------------------------------------------------------
// lzrk_coef
// mode coefficients: s = J*sin, field ramp at three half steps, g = field - J*cos
// ----------------------------------------------------------------------------
module lzrk_coef import lzrk_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  cfg_t              cfg,
  input  word_t             cs,
  input  word_t             sn,
  input  logic [WORD_W-1:0] step,
  output word_t             s,
  output word_t             g0,
  output word_t             g1,
  output word_t             g2,
  output logic              ovf
);

  localparam int JC_W = 34;
  localparam logic signed [63:0] RND30 = 64'sd1 <<< 29;
  localparam logic signed [63:0] WMAX  = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] WMIN  = -64'sh8000_0000;
  localparam logic [65:0]        LIM40 = 66'd1 << 40;

  function automatic logic [WORD_W:0] sat_word(input logic signed [63:0] x);
    if (x > WMAX) return {1'b1, WMAX[WORD_W-1:0]};
    if (x < WMIN) return {1'b1, WMIN[WORD_W-1:0]};
    return {1'b0, x[WORD_W-1:0]};
  endfunction

  logic signed [63:0]     pjs_nxt, pjc_nxt, pjs_r, pjc_r;
  logic [64:0]            pa_nxt [3];
  logic [64:0]            pb_nxt [3];
  logic [64:0]            pa_r [3];
  logic [64:0]            pb_r [3];
  word_t                  s_nxt, s_r;
  logic signed [JC_W-1:0] jc_nxt, jc_r;
  word_t                  fld_nxt [3];
  word_t                  fld_r [3];
  logic                   ovf_nxt, ovf_r;
  logic [WORD_W:0]        gsat [3];

  // products
  always_comb begin : mul_stage
    logic [33:0] hs;
    pjs_nxt = 64'($signed(cfg.coupling)) * 64'($signed(sn));
    pjc_nxt = 64'($signed(cfg.coupling)) * 64'($signed(cs));
    for (int i = 0; i < 3; i++) begin
      hs        = {step, 1'b0} + 34'(i);
      pa_nxt[i] = 65'(cfg.slope_mag) * 65'(hs[33:17]);
      pb_nxt[i] = 65'(cfg.slope_mag) * 65'(hs[16:0]);
    end
  end

  // rounding, ramp clamp, field saturation
  always_comb begin : field_stage
    logic signed [63:0] sf, jf, ff;
    logic [65:0]        q, tot;
    logic [WORD_W:0]    sw;
    sf      = (pjs_r + RND30) >>> 30;
    sw      = sat_word(sf);
    s_nxt   = sw[WORD_W-1:0];
    ovf_nxt = sw[WORD_W];
    jf      = (pjc_r + RND30) >>> 30;
    jc_nxt  = jf[JC_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q = (66'(pb_r[i]) + 66'(1 << 16)) >> 17;
      if (66'(pa_r[i]) > LIM40) tot = LIM40;
      else                      tot = 66'(pa_r[i]) + q;
      if (tot > LIM40) tot = LIM40;
      if (cfg.neg) ff = 64'($signed(cfg.field_start)) - 64'(tot[40:0]);
      else         ff = 64'($signed(cfg.field_start)) + 64'(tot[40:0]);
      sw         = sat_word(ff);
      fld_nxt[i] = sw[WORD_W-1:0];
      ovf_nxt    = ovf_nxt | sw[WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pjs_r <= pjs_nxt;
      pjc_r <= pjc_nxt;
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      s_r   <= s_nxt;
      jc_r  <= jc_nxt;
      fld_r <= fld_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gsat[i] = sat_word(64'($signed(fld_r[i])) - 64'($signed(jc_r)));
    end
  end

  assign s   = s_r;
  assign g0  = gsat[0][WORD_W-1:0];
  assign g1  = gsat[1][WORD_W-1:0];
  assign g2  = gsat[2][WORD_W-1:0];
  assign ovf = ovf_r | gsat[0][WORD_W] | gsat[1][WORD_W] | gsat[2][WORD_W];

endmodule

[rtl/lzrk_deriv.sv]
// ----------------------------------------------------------------------------
// lzrk_deriv
// stage derivative: du = i(g*u + s*v), dv = i(s*u - g*v), products registered
// ----------------------------------------------------------------------------
module lzrk_deriv import lzrk_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t g,
  input  word_t s,
  input  amp4_t amp,
  output k4_t   d
);

  localparam logic signed [63:0] RND24 = 64'sd1 <<< 23;

  logic signed [63:0] p_nxt [8];
  logic signed [63:0] p_r [8];
  logic signed [39:0] r [8];
  kval_t              au, bu, av, bv;

  always_comb begin
    p_nxt[0] = 64'($signed(g)) * 64'($signed(amp[0]));
    p_nxt[1] = 64'($signed(s)) * 64'($signed(amp[2]));
    p_nxt[2] = 64'($signed(g)) * 64'($signed(amp[1]));
    p_nxt[3] = 64'($signed(s)) * 64'($signed(amp[3]));
    p_nxt[4] = 64'($signed(s)) * 64'($signed(amp[0]));
    p_nxt[5] = 64'($signed(g)) * 64'($signed(amp[2]));
    p_nxt[6] = 64'($signed(s)) * 64'($signed(amp[1]));
    p_nxt[7] = 64'($signed(g)) * 64'($signed(amp[3]));
  end

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end

  always_comb begin : sum_stage
    logic signed [63:0] t;
    for (int i = 0; i < 8; i++) begin
      t    = p_r[i] + RND24;
      r[i] = t[63:24];
    end
    au   = K_W'(r[0]) + K_W'(r[1]);
    bu   = K_W'(r[2]) + K_W'(r[3]);
    av   = K_W'(r[4]) - K_W'(r[5]);
    bv   = K_W'(r[6]) - K_W'(r[7]);
    d[0] = -bu;
    d[1] = au;
    d[2] = -bv;
    d[3] = av;
  end

endmodule

[rtl/lzrk_hmul.sv]
// ----------------------------------------------------------------------------
// lzrk_hmul
// amplitude update a + round(x*m / 2^SHIFT), saturated to the amplitude width
// ----------------------------------------------------------------------------
module lzrk_hmul import lzrk_pkg::*; #(
  parameter int X_W   = K_W,
  parameter int SHIFT = 33,
  parameter int AMP_W = AMP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [X_W-1:0] x,
  input  logic [MUL_W-1:0]      m,
  input  word_t                 a,
  output word_t                 y,
  output logic                  ovf
);

  localparam int PA_W = X_W + MUL_W - 16 + 1;
  localparam int PB_W = X_W + 17;
  localparam int T_W  = PA_W + 1;
  localparam int Y_W  = T_W + 1;
  localparam logic signed [T_W-1:0] RND = T_W'(1) <<< (SHIFT - 17);
  localparam logic signed [Y_W-1:0] HI  = (Y_W'(1) <<< (AMP_W - 1)) - Y_W'(1);
  localparam logic signed [Y_W-1:0] LO  = ~HI;

  logic signed [PA_W-1:0] pa_nxt, pa_r;
  logic signed [PB_W-1:0] pb_nxt, pb_r, b;
  word_t                  a_r;
  logic signed [T_W-1:0]  t, rq;
  logic signed [Y_W-1:0]  yf, ys;

  assign pa_nxt = PA_W'(x) * PA_W'($signed({1'b0, m[MUL_W-1:16]}));
  assign pb_nxt = PB_W'(x) * PB_W'($signed({1'b0, m[15:0]}));

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      a_r  <= a;
    end
  end

  assign b  = pb_r >>> 16;
  assign t  = T_W'(pa_r) + T_W'(b) + RND;
  assign rq = t >>> (SHIFT - 16);
  assign yf = Y_W'(rq) + Y_W'(a_r);

  always_comb begin
    ovf = 1'b1;
    if (yf > HI)      ys = HI;
    else if (yf < LO) ys = LO;
    else begin
      ys  = yf;
      ovf = 1'b0;
    end
  end

  assign y = WORD_W'(ys);

endmodule

[rtl/landau_zener_rk4_step.sv]
// ----------------------------------------------------------------------------
// landau_zener_rk4_step
// one fourth-order runge-kutta step of a two-level momentum mode, pipelined
// ----------------------------------------------------------------------------
// Each input word carries one momentum mode (amplitudes u and v in q2.30,
// cos and sin of k*a, and the step count) and produces exactly one output
// word with the amplitudes after one rk4 step of size h, the step count plus
// one (held at its maximum) and an overflow flag. The block is a 21-stage
// pipeline: a new word is taken every cycle while in_tready is high, and its
// result moves from the last stage into the output register. The depth is set
// by the chain of four derivative evaluations, each followed by a registered
// multiply-and-round amplitude update, on top of three stages for the field
// ramp and coefficients and one for the weighted k sum. A two-entry output
// buffer lets one more word leave the pipeline while the output word is held;
// after that in_tready falls until the held word is taken and the parked word
// moves into the output register. Configuration is meant to change only while
// the pipeline is empty; h/6 follows step_size through ph_r/pl_r and h6_r.
// ----------------------------------------------------------------------------
module landau_zener_rk4_step import lzrk_pkg::*; #(
  parameter int AMP_WIDTH = AMP_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // u_real, u_imag, v_real, v_imag, cos_ka, sin_ka, step_number
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // new_u_real, new_u_imag, new_v_real, new_v_imag, next_step
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  // overflow
  output logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // amplitude width, clamped to the supported range
  localparam int AW = (AMP_WIDTH > AMP_W_MAX) ? AMP_W_MAX :
                      (AMP_WIDTH < AMP_W_MIN) ? AMP_W_MIN : AMP_WIDTH;

  // stage where each result lands in the context line
  localparam int ST_COEF = 3;
  localparam int ST_K1   = 5;
  localparam int ST_S1   = 7;
  localparam int ST_K2   = 9;
  localparam int ST_S2   = 11;
  localparam int ST_K3   = 13;
  localparam int ST_S3   = 15;
  localparam int ST_K4   = 17;
  localparam int ST_SUM  = 18;
  localparam int ST_RES  = 20;
  localparam int NS      = ST_RES + 1;

  cfg_t              cfg;
  logic              en;
  ctx_t              ctx_r [NS];
  ctx_t              ctx_nxt [NS];
  logic [NS-1:0]     v_r;

  word_t             coef_s, coef_g0, coef_g1, coef_g2;
  logic              coef_ovf;
  k4_t               dk1, dk2, dk3, dk4;
  amp4_t             st1, st2, st3, res;
  logic [3:0]        ov1, ov2, ov3, ovr;

  // output register plus skid entry
  logic              out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic [OUT_W-1:0]  out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;
  logic              out_f_r, out_f_nxt, skid_f_r, skid_f_nxt;
  logic              push, pop;
  logic [WORD_W-1:0] last_step, next_step;
  logic [OUT_W-1:0]  push_d;

  lzrk_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // whole pipeline advances together; stops only when the skid entry is full
  assign en        = !skid_v_r;
  assign in_tready = en;

  lzrk_coef u_coef (
    .clk  (clk),
    .en   (en),
    .cfg  (cfg),
    .cs   (ctx_r[0].cs),
    .sn   (ctx_r[0].sn),
    .step (ctx_r[0].step),
    .s    (coef_s),
    .g0   (coef_g0),
    .g1   (coef_g1),
    .g2   (coef_g2),
    .ovf  (coef_ovf)
  );

  // k1 at g(t), k2 and k3 at g(t + h/2), k4 at g(t + h)
  lzrk_deriv u_deriv1 (
    .clk (clk), .en (en), .g (ctx_r[ST_COEF].g0), .s (ctx_r[ST_COEF].s),
    .amp (ctx_r[ST_COEF].a), .d (dk1)
  );
  lzrk_deriv u_deriv2 (
    .clk (clk), .en (en), .g (ctx_r[ST_S1].g1), .s (ctx_r[ST_S1].s),
    .amp (ctx_r[ST_S1].st), .d (dk2)
  );
  lzrk_deriv u_deriv3 (
    .clk (clk), .en (en), .g (ctx_r[ST_S2].g1), .s (ctx_r[ST_S2].s),
    .amp (ctx_r[ST_S2].st), .d (dk3)
  );
  lzrk_deriv u_deriv4 (
    .clk (clk), .en (en), .g (ctx_r[ST_S3].g2), .s (ctx_r[ST_S3].s),
    .amp (ctx_r[ST_S3].st), .d (dk4)
  );

  for (genvar i = 0; i < 4; i++) begin : g_lane
    // u + (h/2) k1
    lzrk_hmul #(.X_W(K_W), .SHIFT(33), .AMP_W(AW)) u_upd1 (
      .clk (clk), .en (en), .x (ctx_r[ST_K1].k1[i]), .m (MUL_W'(cfg.h)),
      .a (ctx_r[ST_K1].a[i]), .y (st1[i]), .ovf (ov1[i])
    );
    // u + (h/2) k2
    lzrk_hmul #(.X_W(K_W), .SHIFT(33), .AMP_W(AW)) u_upd2 (
      .clk (clk), .en (en), .x (ctx_r[ST_K2].k2[i]), .m (MUL_W'(cfg.h)),
      .a (ctx_r[ST_K2].a[i]), .y (st2[i]), .ovf (ov2[i])
    );
    // u + h k3
    lzrk_hmul #(.X_W(K_W), .SHIFT(32), .AMP_W(AW)) u_upd3 (
      .clk (clk), .en (en), .x (ctx_r[ST_K3].k3[i]), .m (MUL_W'(cfg.h)),
      .a (ctx_r[ST_K3].a[i]), .y (st3[i]), .ovf (ov3[i])
    );
    // u + (h/6)(k1 + 2k2 + 2k3 + k4), weight in q0.35
    lzrk_hmul #(.X_W(SUM_W), .SHIFT(35), .AMP_W(AW)) u_final (
      .clk (clk), .en (en), .x (ctx_r[ST_SUM].sum[i]), .m (cfg.h6),
      .a (ctx_r[ST_SUM].a[i]), .y (res[i]), .ovf (ovr[i])
    );
  end

  // context line: each stage copies the previous one and fills in its results
  always_comb begin
    ctx_nxt[0] = ctx_r[0];
    for (int i = 0; i < 4; i++) begin
      ctx_nxt[0].a[i] = WORD_W'($signed(in_tdata[i*WORD_W +: AW]));
    end
    ctx_nxt[0].cs   = in_tdata[4*WORD_W +: WORD_W];
    ctx_nxt[0].sn   = in_tdata[5*WORD_W +: WORD_W];
    ctx_nxt[0].step = in_tdata[6*WORD_W +: WORD_W];
    // step count already at its maximum
    ctx_nxt[0].ovf  = (in_tdata[6*WORD_W +: WORD_W] == '1);
    for (int n = 1; n < NS; n++) begin
      ctx_nxt[n] = ctx_r[n-1];
    end
    ctx_nxt[ST_COEF].s   = coef_s;
    ctx_nxt[ST_COEF].g0  = coef_g0;
    ctx_nxt[ST_COEF].g1  = coef_g1;
    ctx_nxt[ST_COEF].g2  = coef_g2;
    ctx_nxt[ST_COEF].ovf = ctx_r[ST_COEF-1].ovf | coef_ovf;
    ctx_nxt[ST_K1].k1    = dk1;
    ctx_nxt[ST_S1].st    = st1;
    ctx_nxt[ST_S1].ovf   = ctx_r[ST_S1-1].ovf | (|ov1);
    ctx_nxt[ST_K2].k2    = dk2;
    ctx_nxt[ST_S2].st    = st2;
    ctx_nxt[ST_S2].ovf   = ctx_r[ST_S2-1].ovf | (|ov2);
    ctx_nxt[ST_K3].k3    = dk3;
    ctx_nxt[ST_S3].st    = st3;
    ctx_nxt[ST_S3].ovf   = ctx_r[ST_S3-1].ovf | (|ov3);
    ctx_nxt[ST_K4].k4    = dk4;
    for (int i = 0; i < 4; i++) begin
      ctx_nxt[ST_SUM].sum[i] = SUM_W'($signed(ctx_r[ST_SUM-1].k1[i]))
                             + (SUM_W'($signed(ctx_r[ST_SUM-1].k2[i])) <<< 1)
                             + (SUM_W'($signed(ctx_r[ST_SUM-1].k3[i])) <<< 1)
                             + SUM_W'($signed(ctx_r[ST_SUM-1].k4[i]));
    end
    ctx_nxt[ST_RES].res  = res;
    ctx_nxt[ST_RES].ovf  = ctx_r[ST_RES-1].ovf | (|ovr);
  end

  always_ff @(posedge clk) begin
    if (en) ctx_r <= ctx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  // result word from the last stage
  assign last_step = ctx_r[NS-1].step;
  assign next_step = (last_step == '1) ? last_step : last_step + WORD_W'(1);
  assign push_d    = {next_step, ctx_r[NS-1].res};
  assign push      = en && v_r[NS-1];
  assign pop       = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    out_f_nxt  = out_f_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    skid_f_nxt = skid_f_r;
    if (push) begin
      if (!out_v_r || pop) begin
        out_v_nxt = 1'b1;
        out_d_nxt = push_d;
        out_f_nxt = ctx_r[NS-1].ovf;
      end else begin
        // output still held, park the word
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_d;
        skid_f_nxt = ctx_r[NS-1].ovf;
      end
    end else if (pop) begin
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        out_f_nxt  = skid_f_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    out_f_r  <= out_f_nxt;
    skid_d_r <= skid_d_nxt;
    skid_f_r <= skid_f_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_f_r;

`ifndef NO_ASSERTIONS
  // the skid entry only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid without output word");

  // a parked word stays until the output is taken
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r)
    else $error("parked word lost");

  // a word leaving the last stage is never dropped; the output register then holds a word
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[NS-1] |=> out_v_r)
    else $error("pipeline word dropped");

  // the step count never wraps to zero
  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_d_r[OUT_W-1 -: WORD_W] != '0)
    else $error("next step wrapped");
`endif

endmodule
